// File: hw/rtl/pds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and codes of the process dispatch scheduler: the item structs
// of both channels, the table entry layout and the operation, policy, event
// and register codes.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_INSERT   = 2'd0;
  localparam logic [1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [1:0] FUNC_UNBLOCK  = 2'd2;
  localparam logic [1:0] FUNC_RSVD     = 2'd3;

  // Dispatch policies; the unused code behaves as first come first served.
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;

  // Result event codes.
  localparam logic [2:0] EV_INSERTED  = 3'd0;
  localparam logic [2:0] EV_FINISHED  = 3'd1;
  localparam logic [2:0] EV_BLOCKED   = 3'd2;
  localparam logic [2:0] EV_EXPIRED   = 3'd3;
  localparam logic [2:0] EV_UNBLOCKED = 3'd4;
  localparam logic [2:0] EV_NONE      = 3'd5;
  localparam logic [2:0] EV_FULL      = 3'd6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd1;

  // Ticks a process runs before it blocks, per policy family.
  localparam logic [7:0] RUN_BLK_RR    = 8'd1;
  localparam logic [7:0] RUN_BLK_OTHER = 8'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] burst_time;
    logic       run_to_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] proc_id;
    logic [7:0]  time_run;
    logic [7:0]  time_left;
  } out_item_t;

  // One row of the process table.
  typedef struct packed {
    logic [15:0] pid;
    logic        blocked;
    logic [7:0]  ptime;
  } entry_t;

endpackage

// File: hw/rtl/pds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/process_dispatch_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_dispatch_scheduler_top
// Process table with insert, unblock and policy driven dispatch.
// ----------------------------------------------------------------------------
// Usage: an item on the in_ channel is an operation (insert, dispatch or
// unblock). Every operation but the reserved code gives one result item on
// the out_ channel. The user writes policy and quantum through the cfg_ port
// while the block is idle; the block does not enforce it. cfg_ready is always high.
// Timing: the table sits in a RAM with one write and one read port, which a
// small sequencer walks one entry per cycle. An insert passes the insert and
// emit states before its result reaches the output register. A dispatch or
// unblock scans the table, then, when an entry leaves or moves to the end,
// slides the later entries down one per cycle. in_stall is high for the
// whole operation.
// Reset: the table empties, the id counter and round robin cursor clear,
// policy returns to first come first served and quantum to 2.
// Stall: a finished result is held in the output register while out_stall is
// high; the next item is still accepted, and its result waits until the
// output register frees up.
// ----------------------------------------------------------------------------
module process_dispatch_scheduler_top
  import pds_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int unsigned AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_SCAN, S_ACT, S_SHIFT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SM_FIRST_READY, SM_SHORTEST, SM_FIRST_BLOCKED
  } scan_mode_t;

  state_t      state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  logic [1:0]  policy_r, policy_nxt;
  logic [7:0]  quantum_r, quantum_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  scan_mode_t  mode_r, mode_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic        rv_r, rv_nxt;
  logic [AW-1:0] rpos_r, rpos_nxt;
  logic        found_r, found_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  entry_t      ent_r, ent_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic        wv_r, wv_nxt;
  logic [AW-1:0] wdst_r, wdst_nxt;
  logic        tail_r, tail_nxt;
  entry_t      tail_ent_r, tail_ent_nxt;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata_raw;
  entry_t        ram_rdata;

  logic in_acc;
  logic scan_match;

  // Outcome of the operation once the scan is done.
  out_item_t     dec_res;
  logic          dec_remove;
  logic          dec_move;
  logic          dec_inplace;
  logic          dec_blk;
  logic [7:0]    dec_time;
  logic [AW-1:0] dec_cursor;

  logic          is_rr;
  logic [7:0]    run_ticks;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] pos_p1;
  logic [AW-1:0] cur_dec;
  logic [AW-1:0] cur_take;
  logic [AW-1:0] cur_rr_rm;
  logic [AW-1:0] cur_exp;

  pds_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry test of the scan for the current mode.
  always_comb begin
    unique case (mode_r)
      SM_FIRST_READY:   scan_match = rv_r && !ram_rdata.blocked;
      SM_SHORTEST:      scan_match = rv_r && !ram_rdata.blocked &&
                                     (!found_r || (ram_rdata.ptime < ent_r.ptime));
      SM_FIRST_BLOCKED: scan_match = rv_r && ram_rdata.blocked;
      default:          scan_match = 1'b0;
    endcase
  end

  // Cursor arithmetic for the entry that was picked.
  assign is_rr     = (policy_r == POL_RR);
  assign run_ticks = is_rr ? RUN_BLK_RR : RUN_BLK_OTHER;
  assign cnt_m1    = count_r - CW'(1);
  assign pos_p1    = CW'(pos_r) + CW'(1);
  assign cur_dec   = (pos_r < cursor_r) ? cursor_r - AW'(1) : cursor_r;
  assign cur_take  = (CW'(cur_dec) >= cnt_m1) ? '0 : cur_dec;
  assign cur_rr_rm = (CW'(pos_r) < cnt_m1) ? pos_r : '0;
  assign cur_exp   = (pos_p1 < count_r) ? AW'(pos_p1) : '0;

  // Decide what happens to the picked entry.
  always_comb begin
    dec_res     = '{event_res: EV_NONE, proc_id: 16'd0, time_run: 8'd0, time_left: 8'd0};
    dec_remove  = 1'b0;
    dec_move    = 1'b0;
    dec_inplace = 1'b0;
    dec_blk     = 1'b0;
    dec_time    = ent_r.ptime;
    dec_cursor  = cursor_r;
    if (found_r) begin
      if (item_r.func == FUNC_UNBLOCK) begin
        dec_res    = '{event_res: EV_UNBLOCKED, proc_id: ent_r.pid, time_run: 8'd0,
                       time_left: ent_r.ptime};
        dec_move   = 1'b1;
        dec_cursor = cur_take;
      end else if (item_r.run_to_end) begin
        if (is_rr) begin
          if (ent_r.ptime <= quantum_r) begin
            dec_res    = '{event_res: EV_FINISHED, proc_id: ent_r.pid,
                           time_run: ent_r.ptime, time_left: 8'd0};
            dec_remove = 1'b1;
            dec_cursor = cur_rr_rm;
          end else begin
            dec_time    = ent_r.ptime - quantum_r;
            dec_res     = '{event_res: EV_EXPIRED, proc_id: ent_r.pid,
                            time_run: quantum_r, time_left: ent_r.ptime - quantum_r};
            dec_inplace = 1'b1;
            dec_cursor  = cur_exp;
          end
        end else begin
          dec_res    = '{event_res: EV_FINISHED, proc_id: ent_r.pid,
                         time_run: ent_r.ptime, time_left: 8'd0};
          dec_remove = 1'b1;
          dec_cursor = cur_take;
        end
      end else if (ent_r.ptime > run_ticks) begin
        dec_time   = ent_r.ptime - run_ticks;
        dec_res    = '{event_res: EV_BLOCKED, proc_id: ent_r.pid,
                       time_run: run_ticks, time_left: ent_r.ptime - run_ticks};
        dec_move   = 1'b1;
        dec_blk    = 1'b1;
        dec_cursor = is_rr ? pos_r : cur_take;
      end else begin
        dec_res    = '{event_res: EV_FINISHED, proc_id: ent_r.pid,
                       time_run: ent_r.ptime, time_left: 8'd0};
        dec_remove = 1'b1;
        dec_cursor = is_rr ? cur_rr_rm : cur_take;
      end
    end
  end

  // Sequencer next state and table port control.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    policy_nxt    = policy_r;
    quantum_nxt   = quantum_r;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    cursor_nxt    = cursor_r;
    mode_nxt      = mode_r;
    p_nxt         = p_r;
    issue_nxt     = issue_r;
    rv_nxt        = 1'b0;
    rpos_nxt      = rpos_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    ent_nxt       = ent_r;
    src_nxt       = src_r;
    lim_nxt       = lim_r;
    wv_nxt        = 1'b0;
    wdst_nxt      = wdst_r;
    tail_nxt      = tail_r;
    tail_ent_nxt  = tail_ent_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ent_r;
    ram_raddr     = p_r;

    // Register writes.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY:  policy_nxt  = cfg_data[1:0];
        CFG_QUANTUM: quantum_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt  = in_data;
          issue_nxt = '0;
          found_nxt = 1'b0;
          p_nxt     = '0;
          unique case (in_data.func)
            FUNC_INSERT: state_nxt = S_INS;
            FUNC_DISPATCH: begin
              mode_nxt = (policy_r == POL_SJF) ? SM_SHORTEST : SM_FIRST_READY;
              if (policy_r == POL_RR && CW'(cursor_r) < count_r) begin
                p_nxt = cursor_r;
              end
              state_nxt = S_SCAN;
            end
            FUNC_UNBLOCK: begin
              mode_nxt  = SM_FIRST_BLOCKED;
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Append a ready entry, or report a full table.
      S_INS: begin
        if (count_r >= CW'(MAX_PROCS)) begin
          res_nxt = '{event_res: EV_FULL, proc_id: 16'd0, time_run: 8'd0, time_left: 8'd0};
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = AW'(count_r);
          ram_wdata   = '{pid: next_id_r + 16'd1, blocked: 1'b0,
                          ptime: item_r.burst_time};
          next_id_nxt = next_id_r + 16'd1;
          count_nxt   = count_r + CW'(1);
          res_nxt     = '{event_res: EV_INSERTED, proc_id: next_id_r + 16'd1,
                          time_run: 8'd0, time_left: item_r.burst_time};
        end
        state_nxt = S_EMIT;
      end

      // Read one entry per cycle and test the one read last cycle.
      S_SCAN: begin
        if (issue_r < count_r) begin
          ram_raddr = p_r;
          rv_nxt    = 1'b1;
          rpos_nxt  = p_r;
          p_nxt     = (CW'(p_r) + CW'(1) == count_r) ? '0 : p_r + AW'(1);
          issue_nxt = issue_r + CW'(1);
        end
        if (scan_match) begin
          found_nxt = 1'b1;
          pos_nxt   = rpos_r;
          ent_nxt   = ram_rdata;
        end
        if (scan_match && mode_r != SM_SHORTEST) begin
          state_nxt = S_ACT;
        end else if (issue_r == count_r && !rv_r) begin
          state_nxt = S_ACT;
        end
      end

      // Apply the outcome: in place update, set up the slide down, or emit directly.
      S_ACT: begin
        res_nxt    = dec_res;
        cursor_nxt = dec_cursor;
        if (dec_inplace) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = '{pid: ent_r.pid, blocked: ent_r.blocked, ptime: dec_time};
          state_nxt = S_EMIT;
        end else if (dec_remove || dec_move) begin
          src_nxt      = pos_p1;
          lim_nxt      = count_r;
          tail_nxt     = dec_move;
          tail_ent_nxt = '{pid: ent_r.pid, blocked: dec_blk, ptime: dec_time};
          count_nxt    = dec_remove ? cnt_m1 : count_r;
          state_nxt    = S_SHIFT;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      // Slide later entries down one slot, then append the moved entry if there is one.
      S_SHIFT: begin
        if (src_r < lim_r) begin
          ram_raddr = AW'(src_r);
          wv_nxt    = 1'b1;
          wdst_nxt  = AW'(src_r - CW'(1));
          src_nxt   = src_r + CW'(1);
        end
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wdst_r;
          ram_wdata = ram_rdata;
        end else if (src_r >= lim_r) begin
          if (tail_r) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(lim_r - CW'(1));
            ram_wdata = tail_ent_r;
          end
          state_nxt = S_EMIT;
        end
      end

      // Hand the result to the output register once it is free.
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FCFS;
      quantum_r   <= 8'd2;
      count_r     <= '0;
      next_id_r   <= 16'd0;
      cursor_r    <= '0;
      mode_r      <= SM_FIRST_READY;
      issue_r     <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      wv_r        <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      quantum_r   <= quantum_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      cursor_r    <= cursor_nxt;
      mode_r      <= mode_nxt;
      issue_r     <= issue_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      wv_r        <= wv_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    p_r        <= p_nxt;
    rpos_r     <= rpos_nxt;
    pos_r      <= pos_nxt;
    ent_r      <= ent_nxt;
    src_r      <= src_nxt;
    lim_r      <= lim_nxt;
    wdst_r     <= wdst_nxt;
    tail_ent_r <= tail_ent_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // The table never holds more entries than it has rows.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_PROCS))
    else $error("entry count exceeds table depth");

  // Every real operation starts the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func != FUNC_RSVD) |=> (state_r != S_IDLE))
    else $error("accepted item did not start an operation");

  // A new result only ever comes from the emit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) ##1 out_valid_r |-> ($past(state_r) == S_EMIT))
    else $error("result presented without an emit step");

  // Between operations the cursor points at a live entry or is zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cursor_r == '0 || CW'(cursor_r) < count_r))
    else $error("round robin cursor beyond table");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the process dispatch scheduler. A directed table
// covers reset state, field extremes, every operation and policy, the empty
// and zero-time cases. Random phases follow, each under its own policy and
// quantum; one phase runs with no idling on either side. Every result is
// checked against a listed value or a behavioral copy of the process table.
// ----------------------------------------------------------------------------
module testbench;
  import pds_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 16;
  localparam int unsigned NUM_PHASES      = 11;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned SEGMENT_LEN     = 25;
  localparam int unsigned NO_IDLE_PHASE   = 5;
  localparam int unsigned SETTLE_CYCLES   = 48;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SJF_NO_BEST     = 1000;
  localparam logic [7:0]  BLOCK_RUN_RR    = 8'd1;
  localparam logic [7:0]  BLOCK_RUN_OTHER = 8'd2;
  localparam logic [1:0]  POL_UNUSED      = 2'd3;

  // Traffic mixes of the random part.
  localparam int unsigned MIX_FILL  = 0;
  localparam int unsigned MIX_DRAIN = 1;
  localparam int unsigned MIX_EVEN  = 2;

  // One row of the directed table: either an item or a register write.
  typedef struct packed {
    logic                 is_cfg;
    in_item_t             op;
    logic                 typed;
    out_item_t            want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_val;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  // Shadow of the process table and registers.
  entry_t      proc_table [TABLE_DEPTH];
  int unsigned proc_count;
  logic [15:0] last_pid;
  int unsigned rr_slot;
  logic [1:0]  sel_policy;
  logic [7:0]  slice_ticks;

  out_item_t   pending_events [$];
  dir_row_t    dir_rows [$];
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned full_hits       = 0;
  int unsigned id_wraps        = 0;
  int unsigned quiet_cycles    = 0;

  process_dispatch_scheduler_top #(
    .MAX_PROCS(TABLE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_item_t mk_res(input logic [2:0] ev, input logic [15:0] pid,
                                       input logic [7:0] run, input logic [7:0] left);
    out_item_t r;
    r.event_res = ev;
    r.proc_id   = pid;
    r.time_run  = run;
    r.time_left = left;
    return r;
  endfunction

  function automatic in_item_t mk_op(input logic [1:0] func, input logic [7:0] burst,
                                     input logic rte);
    in_item_t op;
    op.func       = func;
    op.burst_time = burst;
    op.run_to_end = rte;
    return op;
  endfunction

  function automatic dir_row_t op_row(input logic [1:0] func, input logic [7:0] burst,
                                      input logic rte, input logic typed,
                                      input out_item_t want);
    dir_row_t row;
    row         = '0;
    row.op      = mk_op(func, burst, rte);
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Remove one entry; the round robin slot follows entries that slide down.
  function automatic void tab_remove(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < proc_count; i++) proc_table[i] = proc_table[i + 1];
    proc_count--;
    if (pos < rr_slot) rr_slot--;
    if (rr_slot >= proc_count) rr_slot = 0;
  endfunction

  function automatic void tab_to_end(input int unsigned pos, input logic blk);
    entry_t e;
    e         = proc_table[pos];
    e.blocked = blk;
    tab_remove(pos);
    proc_table[proc_count] = e;
    proc_count++;
  endfunction

  // Pick a ready entry by policy, run it and update the table.
  function automatic out_item_t sched_dispatch(input logic rte);
    int unsigned i, p, pos, start, best;
    bit          found;
    logic [15:0] pid;
    logic [7:0]  t, run;
    pos   = 0;
    found = 1'b0;
    if (sel_policy == POL_SJF) begin
      best = SJF_NO_BEST;
      for (i = 0; i < proc_count; i++) begin
        if (!proc_table[i].blocked && 32'(proc_table[i].ptime) < best) begin
          best  = 32'(proc_table[i].ptime);
          pos   = i;
          found = 1'b1;
        end
      end
    end else if (sel_policy == POL_RR) begin
      start = (rr_slot < proc_count) ? rr_slot : 0;
      for (i = 0; i < proc_count && !found; i++) begin
        p = start + i;
        if (p >= proc_count) p -= proc_count;
        if (!proc_table[p].blocked) begin
          pos   = p;
          found = 1'b1;
        end
      end
    end else begin
      for (i = 0; i < proc_count && !found; i++) begin
        if (!proc_table[i].blocked) begin
          pos   = i;
          found = 1'b1;
        end
      end
    end
    if (!found) return mk_res(EV_NONE, 16'd0, 8'd0, 8'd0);

    pid = proc_table[pos].pid;
    t   = proc_table[pos].ptime;

    // Normal runs: round robin finishes or uses one slice, the others finish.
    if (sel_policy == POL_RR) begin
      if (rte) begin
        if (t <= slice_ticks) begin
          tab_remove(pos);
          rr_slot = (pos < proc_count) ? pos : 0;
          return mk_res(EV_FINISHED, pid, t, 8'd0);
        end
        proc_table[pos].ptime = t - slice_ticks;
        rr_slot = (pos + 1 < proc_count) ? pos + 1 : 0;
        return mk_res(EV_EXPIRED, pid, slice_ticks, t - slice_ticks);
      end
      run = BLOCK_RUN_RR;
    end else begin
      if (rte) begin
        tab_remove(pos);
        return mk_res(EV_FINISHED, pid, t, 8'd0);
      end
      run = BLOCK_RUN_OTHER;
    end

    // Short run: block and move to the end, or finish if time runs out.
    if (t > run) begin
      proc_table[pos].ptime = t - run;
      tab_to_end(pos, 1'b1);
      if (sel_policy == POL_RR) rr_slot = (pos < proc_count) ? pos : 0;
      return mk_res(EV_BLOCKED, pid, run, t - run);
    end
    tab_remove(pos);
    if (sel_policy == POL_RR) rr_slot = (pos < proc_count) ? pos : 0;
    return mk_res(EV_FINISHED, pid, t, 8'd0);
  endfunction

  // Apply one operation to the shadow table and give the result it causes.
  task automatic sched_apply(input in_item_t op, output bit has_res, output out_item_t res);
    int unsigned i;
    has_res = 1'b1;
    res     = '0;
    case (op.func)
      FUNC_INSERT: begin
        if (proc_count >= TABLE_DEPTH) begin
          full_hits++;
          res = mk_res(EV_FULL, 16'd0, 8'd0, 8'd0);
        end else begin
          last_pid++;
          if (last_pid == 16'd0) id_wraps++;
          proc_table[proc_count].pid     = last_pid;
          proc_table[proc_count].blocked = 1'b0;
          proc_table[proc_count].ptime   = op.burst_time;
          proc_count++;
          res = mk_res(EV_INSERTED, last_pid, 8'd0, op.burst_time);
        end
      end
      FUNC_DISPATCH: res = sched_dispatch(op.run_to_end);
      FUNC_UNBLOCK: begin
        for (i = 0; i < proc_count; i++) if (proc_table[i].blocked) break;
        if (i >= proc_count) begin
          res = mk_res(EV_NONE, 16'd0, 8'd0, 8'd0);
        end else begin
          res = mk_res(EV_UNBLOCKED, proc_table[i].pid, 8'd0, proc_table[i].ptime);
          tab_to_end(i, 1'b0);
        end
      end
      default: has_res = 1'b0;
    endcase
  endtask

  // Present one item, hold it until accepted, then record its result.
  task automatic send_op(input in_item_t op, input bit typed, input out_item_t want);
    bit        has_res;
    out_item_t res;
    while (gaps_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sched_apply(op, has_res, res);
    if (has_res) pending_events.push_back(typed ? want : res);
    items_sent++;
  endtask

  // Stop sending and wait until every result is back and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_POLICY) sel_policy = val[1:0];
    else slice_ticks = val;
    @(posedge clk);
  endtask

  function automatic in_item_t rand_op(input int unsigned mix);
    int unsigned roll, ins_lim, disp_lim;
    in_item_t    op;
    op.run_to_end = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < 40) op.burst_time = 8'($urandom_range(6, 1));
    else if (roll < 45) op.burst_time = 8'd0;
    else if (roll < 50) op.burst_time = 8'd255;
    else op.burst_time = 8'($urandom_range(255));
    case (mix)
      MIX_FILL:  begin ins_lim = 65; disp_lim = 90; end
      MIX_DRAIN: begin ins_lim = 15; disp_lim = 75; end
      default:   begin ins_lim = 35; disp_lim = 80; end
    endcase
    roll = $urandom_range(99);
    if (roll < 3) op.func = FUNC_RSVD;
    else if (roll < ins_lim) op.func = FUNC_INSERT;
    else if (roll < disp_lim) op.func = FUNC_DISPATCH;
    else op.func = FUNC_UNBLOCK;
    return op;
  endfunction

  function automatic bit same_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Receiver: random back-pressure on the result channel.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= stalls_on && ($urandom_range(99) < 21);
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin : check_results
    out_item_t want;
    bit        ok;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got event %0d id %0d run %0d left %0d",
                 $time, out_data.event_res, out_data.proc_id, out_data.time_run,
                 out_data.time_left);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        ok = same_field("event_res", 16'(want.event_res), 16'(out_data.event_res))
           & same_field("proc_id", want.proc_id, out_data.proc_id)
           & same_field("time_run", 16'(want.time_run), 16'(out_data.time_run))
           & same_field("time_left", 16'(want.time_left), 16'(out_data.time_left));
        if (!ok) mismatch_count++;
        results_checked++;
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, quiet_cycles);
      $display("** process_dispatch_scheduler_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned ph, iter, counted, mix;
    logic [1:0]  pol;
    logic [7:0]  quant;
    in_item_t    op;
    dir_row_t    row;

    proc_count  = 0;
    last_pid    = 16'd0;
    rr_slot     = 0;
    sel_policy  = POL_FCFS;
    slice_ticks = 8'd2;

    // Directed table: reset state, extremes, each policy and special case.
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b1,
                              mk_res(EV_NONE, 16'd0, 8'd0, 8'd0)));
    dir_rows.push_back(op_row(FUNC_UNBLOCK, 8'd0, 1'b0, 1'b1,
                              mk_res(EV_NONE, 16'd0, 8'd0, 8'd0)));
    dir_rows.push_back(op_row(FUNC_RSVD, 8'd255, 1'b1, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_INSERT, 8'd255, 1'b0, 1'b1,
                              mk_res(EV_INSERTED, 16'd1, 8'd0, 8'd255)));
    dir_rows.push_back(op_row(FUNC_INSERT, 8'd0, 1'b1, 1'b1,
                              mk_res(EV_INSERTED, 16'd2, 8'd0, 8'd0)));
    dir_rows.push_back(op_row(FUNC_INSERT, 8'd1, 1'b0, 1'b1,
                              mk_res(EV_INSERTED, 16'd3, 8'd0, 8'd1)));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b0, 1'b1,
                              mk_res(EV_BLOCKED, 16'd1, 8'd2, 8'd253)));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b1,
                              mk_res(EV_FINISHED, 16'd2, 8'd0, 8'd0)));
    dir_rows.push_back(op_row(FUNC_UNBLOCK, 8'd0, 1'b1, 1'b1,
                              mk_res(EV_UNBLOCKED, 16'd1, 8'd0, 8'd253)));
    dir_rows.push_back(cfg_row(CFG_POLICY, 8'(POL_SJF)));
    dir_rows.push_back(op_row(FUNC_INSERT, 8'd128, 1'b1, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b0, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_POLICY, 8'(POL_RR)));
    dir_rows.push_back(cfg_row(CFG_QUANTUM, 8'd255));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b1,
                              mk_res(EV_NONE, 16'd0, 8'd0, 8'd0)));
    dir_rows.push_back(op_row(FUNC_UNBLOCK, 8'd0, 1'b0, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_QUANTUM, 8'd0));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_QUANTUM, 8'd1));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b0, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_INSERT, 8'd2, 1'b0, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_POLICY, 8'(POL_UNUSED)));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b0, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_INSERT, 8'd3, 1'b1, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b0, 1'b0, '0));
    dir_rows.push_back(op_row(FUNC_DISPATCH, 8'd0, 1'b1, 1'b0, '0));

    // Hold reset, then release it.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_op(row.op, row.typed, row.want);
      end
    end

    // Random phases, each with its own register setting.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin pol = POL_RR;     quant = 8'd1; end
        1:       begin pol = POL_RR;     quant = 8'd255; end
        2:       begin pol = POL_SJF;    quant = 8'($urandom_range(255)); end
        3:       begin pol = POL_FCFS;   quant = 8'($urandom_range(255)); end
        4:       begin pol = POL_RR;     quant = 8'd0; end
        5:       begin pol = POL_UNUSED; quant = 8'($urandom_range(255)); end
        6:       begin pol = POL_RR;     quant = 8'($urandom_range(8, 1)); end
        7:       begin pol = POL_SJF;    quant = 8'd1; end
        8:       begin pol = POL_RR;     quant = 8'($urandom_range(6, 2)); end
        9:       begin pol = POL_FCFS;   quant = 8'd255; end
        default: begin pol = POL_RR;     quant = 8'($urandom_range(255, 1)); end
      endcase
      settle();
      write_reg(CFG_POLICY, 8'(pol));
      write_reg(CFG_QUANTUM, quant);

      // One whole phase runs with no idling on either side.
      if (ph == NO_IDLE_PHASE) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end

      counted = 0;
      iter    = 0;
      mix     = MIX_EVEN;
      while (counted < ITEMS_PER_PHASE) begin
        if (iter % SEGMENT_LEN == 0) mix = $urandom_range(2);
        // Midway through, hold off until the block has drained its results.
        if (iter == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_events.size() != 0);
        end
        op = rand_op(mix);
        send_op(op, 1'b0, '0);
        if (op.func != FUNC_RSVD) counted++;
        iter++;
      end

      gaps_on   = 1'b1;
      stalls_on = 1'b1;
    end

    settle();
    $display("Covered %0d items and %0d results over %0d policy/quantum phases.",
             items_sent, results_checked, NUM_PHASES);
    $display("Table-full events: %0d, id counter wraps: %0d, mismatches: %0d.",
             full_hits, id_wraps, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** process_dispatch_scheduler_top: PASSED **");
    end else begin
      $display("** process_dispatch_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
